### src/lsbe_pkg.sv
// lsbe_pkg: shared constants, types and helpers of the led strip bit encoder
// used by lsbe_pixel_ram, lsbe_serializer and rgb_led_strip_bit_encoder_core
// no dependencies
`default_nettype none

package lsbe_pkg;

    // frame geometry
    localparam int PIXEL_COUNT = 256;
    localparam int RESET_SLOTS = 64;
    localparam int CODE_BITS   = 24;

    // slot counter stops at the last gap slot plus one
    localparam int SLOT_CEIL = RESET_SLOTS + PIXEL_COUNT + 1;
    localparam int SLOT_W    = $clog2(SLOT_CEIL + 1);
    localparam int IDX_W     = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CNT_W     = $clog2(CODE_BITS + 1);

    // beat field widths
    localparam int INDEX_W = 16;
    localparam int COLOR_W = 24;

    // pulse width codes
    localparam logic [1:0] CODE_ONE  = 2'd3;
    localparam logic [1:0] CODE_ZERO = 2'd1;
    localparam logic [1:0] CODE_GAP  = 2'd0;

    // input beat kinds
    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_FILL_LO = 2'd1,
        MODE_FILL_HI = 2'd2,
        MODE_IGNORE  = 2'd3
    } mode_t;

    // one refill handed to the serializer
    typedef struct packed {
        logic                 half;
        logic                 gap;
        logic [CODE_BITS-1:0] grb;
    } lsbe_load_t;

    // rgb to grb byte swap
    function automatic logic [COLOR_W-1:0] to_grb(input logic [COLOR_W-1:0] rgb);
        return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

endpackage

`default_nettype wire

### src/lsbe_pixel_ram.sv
// lsbe_pixel_ram: pixel store, one write and one registered read port
// per-entry valid bits make unwritten entries read as zero after reset
// depends on lsbe_pkg
`default_nettype none

module lsbe_pixel_ram (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [lsbe_pkg::IDX_W-1:0]    wr_addr,
    input  wire logic [lsbe_pkg::COLOR_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [lsbe_pkg::IDX_W-1:0]    rd_addr,
    output logic      [lsbe_pkg::COLOR_W-1:0]  rd_data
);
    import lsbe_pkg::*;

    logic [COLOR_W-1:0]     mem [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] valid_reg;
    logic [COLOR_W-1:0]     rd_data_reg;
    logic                   rd_hit_reg;

    // storage array, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // written-entry flags, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### src/lsbe_serializer.sv
// lsbe_serializer: turns one loaded pixel word into 24 pulse codes, msb first
// holds the current code as the registered output beat
// depends on lsbe_pkg
`default_nettype none

module lsbe_serializer (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lsbe_pkg::lsbe_load_t load,
    input  wire logic                 load_en,
    output logic                      load_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                out_code,
    output logic                      out_half,
    output logic                      out_last
);
    import lsbe_pkg::*;

    logic [CODE_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 half_reg, half_next;
    logic                 gap_reg, gap_next;
    logic                 beat_done;

    assign out_valid  = (cnt_reg != '0);
    assign beat_done  = out_valid && out_ready;
    // free when idle or when the final code leaves this cycle
    assign load_ready = !out_valid || (beat_done && cnt_reg == CNT_W'(1));

    assign out_last = (cnt_reg == CNT_W'(1));
    assign out_half = half_reg;
    assign out_code = gap_reg ? CODE_GAP : (shift_reg[CODE_BITS-1] ? CODE_ONE : CODE_ZERO);

    // load a new run or step to the next code
    always_comb begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        half_next  = half_reg;
        gap_next   = gap_reg;
        if (load_en) begin
            shift_next = load.grb;
            cnt_next   = CNT_W'(CODE_BITS);
            half_next  = load.half;
            gap_next   = load.gap;
        end else if (beat_done) begin
            shift_next = {shift_reg[CODE_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg - CNT_W'(1);
        end
    end

    // code counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        half_reg  <= half_next;
        gap_reg   <= gap_next;
    end

    // checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CODE_BITS))
        else $error("code counter out of range");

    a_load_full: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |=> cnt_reg == CNT_W'(CODE_BITS))
        else $error("load did not start a full run");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |-> (cnt_reg == '0 || (cnt_reg == CNT_W'(1) && out_ready)))
        else $error("load while a run is still in flight");

endmodule

`default_nettype wire

### src/rgb_led_strip_bit_encoder_core.sv
// rgb_led_strip_bit_encoder_core: top level of the led strip bit encoder
// pixel store, slot counter and read stage feeding the code serializer
// depends on lsbe_pkg, lsbe_pixel_ram, lsbe_serializer

// A pixel write (mode 0) produces no output beat. A refill (mode 1 or 2)
// reads the pixel at the slot counter from the 256-entry store through a
// registered read port and serializes it as 24 code beats, one per cycle at
// full output rate; a gap slot reads nothing and sends gap codes. With the
// serializer idle, the first code of a refill is presented once the refill
// has passed the read stage into the serializer. Writes are taken every
// cycle while a run is sent, as long as no refill waits in the read stage. A
// refill taken during a run waits in the read stage until the last code of
// that run leaves, which holds s_tready low meanwhile for every beat kind;
// the runs of back-to-back refills then follow each other without a gap. The
// store reads as zero after reset through per-entry written flags, so no
// clearing pass is needed and the block accepts beats right after reset.
`default_nettype none

module rgb_led_strip_bit_encoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // pixel_index [15:0], rgb_color [39:16]
    input  wire logic [1:0]  s_tuser,   // mode [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // pulse_code [1:0], zero [7:2]
    output logic [0:0]       m_tuser,   // buffer_half [0]
    output logic             m_tlast    // last_of_run
);
    import lsbe_pkg::*;

    localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(PIXEL_COUNT);
    localparam logic [SLOT_W-1:0]  GAP_START   = SLOT_W'(PIXEL_COUNT);
    localparam logic [SLOT_W-1:0]  WRAP_LIMIT  = SLOT_W'(RESET_SLOTS + PIXEL_COUNT);
    localparam logic [SLOT_W-1:0]  SLOT_TOP    = SLOT_W'(SLOT_CEIL);

    mode_t              in_mode;
    logic [INDEX_W-1:0] in_index;
    logic [COLOR_W-1:0] in_color;
    logic               accept;
    logic               fill_acc;
    logic               fill_hi;
    logic               cur_gap;
    logic               wr_en;
    logic [SLOT_W-1:0]  slot_reg, slot_next, slot_inc;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_half_reg;
    logic               s1_gap_reg;
    logic               s1_take;
    logic [COLOR_W-1:0] rd_data;
    lsbe_load_t         ser_load;
    logic               ser_ready;
    logic [1:0]         ser_code;
    logic               ser_half;

    // beat unpacking
    assign in_mode  = mode_t'(s_tuser);
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_color = s_tdata[INDEX_W+COLOR_W-1:INDEX_W];

    // read stage may hold one refill while the serializer is busy
    assign s1_take  = ser_ready;
    assign s_tready = !s1_valid_reg || s1_take;
    assign accept   = s_tvalid && s_tready;

    // decode the beat kind
    always_comb begin
        wr_en    = 1'b0;
        fill_acc = 1'b0;
        fill_hi  = 1'b0;
        case (in_mode)
            MODE_WRITE: begin
                wr_en = accept && (in_index < INDEX_LIMIT);
            end
            MODE_FILL_LO: begin
                fill_acc = accept;
            end
            MODE_FILL_HI: begin
                fill_acc = accept;
                fill_hi  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // slot counter: step, saturate, wrap after the gap on second-half refills
    assign cur_gap  = (slot_reg >= GAP_START);
    assign slot_inc = (slot_reg < SLOT_TOP) ? slot_reg + SLOT_W'(1) : slot_reg;

    always_comb begin
        slot_next = slot_reg;
        if (fill_acc) begin
            slot_next = slot_inc;
            if (cur_gap && fill_hi && slot_inc > WRAP_LIMIT) begin
                slot_next = '0;
            end
        end
    end

    // read stage occupancy
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (fill_acc) begin
            s1_valid_next = 1'b1;
        end else if (s1_take) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            slot_reg     <= slot_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // read stage payload
    always_ff @(posedge aclk) begin
        if (fill_acc) begin
            s1_half_reg <= fill_hi;
            s1_gap_reg  <= cur_gap;
        end
    end

    // pixel store
    lsbe_pixel_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (in_index[IDX_W-1:0]),
        .wr_data (to_grb(in_color)),
        .rd_en   (fill_acc && !cur_gap),
        .rd_addr (slot_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // hand the read result to the serializer
    always_comb begin
        ser_load.half = s1_half_reg;
        ser_load.gap  = s1_gap_reg;
        ser_load.grb  = s1_gap_reg ? '0 : rd_data;
    end

    lsbe_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (ser_load),
        .load_en    (s1_valid_reg && s1_take),
        .load_ready (ser_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_code   (ser_code),
        .out_half   (ser_half),
        .out_last   (m_tlast)
    );

    // output beat packing
    assign m_tdata    = {6'b0, ser_code};
    assign m_tuser[0] = ser_half;

    // checks
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_TOP)
        else $error("slot counter past its ceiling");

    a_fill_staged: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_acc |=> s1_valid_reg)
        else $error("accepted refill missing from read stage");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_take) |=> (s1_valid_reg && $stable(s1_half_reg)
            && $stable(s1_gap_reg)))
        else $error("waiting refill lost or changed");

endmodule

`default_nettype wire
